@@ src/assert_macros.svh @@
// assertion macros for the thermistor window average lookup
// clocked on clk_i with reset rst_ni of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define TWAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define TWAL_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ src/twal_pkg.sv @@
// shared constants, lookup thresholds and types of the thermistor lookup
// no dependencies
`timescale 1ns / 1ps

package twal_pkg;

  localparam int unsigned WINDOW_DEF      = 10;
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned TABLE_LEN   = 19;
  localparam int unsigned POS_BITS    = 5;
  localparam int unsigned TEMP_BITS   = 7;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned TEMP_STEP   = 5;
  localparam int unsigned THRESH_BITS = 10;

  // smallest mean that puts the coefficient at or below each ratio entry,
  // i.e. ceil(32652 / ratio_q8) for the descending q8.8 ratio table
  localparam logic [THRESH_BITS-1:0] THRESH [TABLE_LEN] = '{
    10'd17,  10'd21,  10'd27,  10'd35,  10'd44,  10'd55,  10'd69,
    10'd85,  10'd105, 10'd128, 10'd156, 10'd188, 10'd229, 10'd273,
    10'd327, 10'd389, 10'd454, 10'd554, 10'd641
  };

  localparam logic [TEMP_BITS-1:0] TEMP_MAX = TEMP_BITS'((TABLE_LEN - 1) * TEMP_STEP);

  typedef enum logic [STATUS_BITS-1:0] {
    RANGE_IN   = 2'd0,
    RANGE_LOW  = 2'd1,
    RANGE_HIGH = 2'd2
  } range_status_e;

endpackage

@@ src/twal_sample_if.sv @@
// sample channel: valid, ready and one adc sample
// depends on twal_pkg
`timescale 1ns / 1ps

interface twal_sample_if import twal_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ src/twal_result_if.sv @@
// result channel: valid, ready, window mean, temperature and range status
// depends on twal_pkg
`timescale 1ns / 1ps

interface twal_result_if import twal_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] mean_value;
  logic [TEMP_BITS-1:0]   temperature;
  logic [STATUS_BITS-1:0] range_status;

  modport source (output valid, output mean_value, output temperature,
                  output range_status, input ready);
  modport sink   (input valid, input mean_value, input temperature,
                  input range_status, output ready);
endinterface

@@ src/twal_front.sv @@
// front end: sample ring and running window total, one sample per cycle while the queue has room
// depends on twal_pkg
`timescale 1ns / 1ps

module twal_front import twal_pkg::*; #(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned TOTAL_BITS = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   smp_valid_i,
  output logic                   smp_ready_o,
  input  logic [SAMPLE_BITS-1:0] smp_i,
  output logic                   total_valid_o,
  input  logic                   total_ready_i,
  output logic [TOTAL_BITS-1:0]  total_o
);

  localparam int unsigned SLOT_BITS = $clog2(WINDOW);

  logic [SAMPLE_BITS-1:0] ring_q [WINDOW];
  logic [SLOT_BITS-1:0]   slot_q, slot_d;
  logic [TOTAL_BITS-1:0]  total_q, total_d;
  logic                   accept;

  assign accept        = smp_valid_i && total_ready_i;
  assign smp_ready_o   = total_ready_i;
  assign total_valid_o = smp_valid_i;

  // drop the oldest sample, add the new one
  assign total_d = total_q - TOTAL_BITS'(ring_q[slot_q]) + TOTAL_BITS'(smp_i);
  assign total_o = total_d;

  // wrapping write slot
  assign slot_d = (slot_q == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_q[i] <= '0;
      end
      slot_q  <= '0;
      total_q <= '0;
    end else if (accept) begin
      ring_q[slot_q] <= smp_i;
      slot_q         <= slot_d;
      total_q        <= total_d;
    end
  end

endmodule

@@ src/twal_queue.sv @@
// short queue of window totals between front and back end
// depends on twal_pkg
`timescale 1ns / 1ps

module twal_queue import twal_pkg::*; #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;
  logic                push, pop;

  assign push_ready_o = (count_q != CNT_BITS'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ src/twal_back.sv @@
// back end: mean by reciprocal multiply, table classification, output register
// depends on twal_pkg
`timescale 1ns / 1ps

module twal_back import twal_pkg::*; #(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned TOTAL_BITS = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   total_valid_i,
  output logic                   total_ready_o,
  input  logic [TOTAL_BITS-1:0]  total_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [SAMPLE_BITS-1:0] mean_o,
  output logic [TEMP_BITS-1:0]   temp_o,
  output logic [STATUS_BITS-1:0] status_o
);

  localparam int unsigned PROD_BITS = 2 * TOTAL_BITS;
  localparam int unsigned CMP_BITS  = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
  // floor(2^TOTAL_BITS / WINDOW): quotient estimate is low by at most one
  localparam logic [TOTAL_BITS-1:0] RECIP = TOTAL_BITS'((64'd1 << TOTAL_BITS) / WINDOW);

  logic                   s1_valid_q, s2_valid_q, s3_valid_q;
  logic                   s1_ready, s2_ready, s3_ready;
  logic [PROD_BITS-1:0]   s1_prod_q;
  logic [TOTAL_BITS-1:0]  s1_total_q;
  logic [SAMPLE_BITS-1:0] s2_mean_q, s3_mean_q;
  logic [TEMP_BITS-1:0]   s3_temp_q;
  range_status_e          s3_status_q;

  logic [SAMPLE_BITS-1:0] quot_est, mean_d;
  logic [TOTAL_BITS-1:0]  rem;
  logic [TABLE_LEN-1:0]   hit;
  logic [POS_BITS-1:0]    pos;
  logic [TEMP_BITS-1:0]   temp_d;
  range_status_e          status_d;

  // stage handshake: a stage takes new data when empty or draining
  assign s3_ready      = !s3_valid_q || res_ready_i;
  assign s2_ready      = !s2_valid_q || s3_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign total_ready_o = s1_ready;

  // stage 2: quotient estimate and one-step correction
  assign quot_est = s1_prod_q[TOTAL_BITS +: SAMPLE_BITS];
  assign rem      = s1_total_q - TOTAL_BITS'(quot_est) * TOTAL_BITS'(WINDOW);
  assign mean_d   = (rem >= TOTAL_BITS'(WINDOW)) ? quot_est + 1'b1 : quot_est;

  // stage 3: threshold compares give the table position
  always_comb begin
    for (int i = 0; i < TABLE_LEN; i++) begin
      hit[i] = (CMP_BITS'(s2_mean_q) >= CMP_BITS'(THRESH[i]));
    end
  end
  assign pos = POS_BITS'($countones(hit));

  always_comb begin
    if (pos == '0) begin
      temp_d   = '0;
      status_d = RANGE_LOW;
    end else if (pos >= POS_BITS'(TABLE_LEN)) begin
      temp_d   = TEMP_MAX;
      status_d = RANGE_HIGH;
    end else begin
      temp_d   = (TEMP_BITS'(pos) - 1'b1) * TEMP_BITS'(TEMP_STEP);
      status_d = RANGE_IN;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= total_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s1_ready && total_valid_i) begin
      s1_prod_q  <= PROD_BITS'(total_i) * PROD_BITS'(RECIP);
      s1_total_q <= total_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_mean_q <= mean_d;
    end
    if (s3_ready && s2_valid_q) begin
      s3_mean_q   <= s2_mean_q;
      s3_temp_q   <= temp_d;
      s3_status_q <= status_d;
    end
  end

  assign res_valid_o = s3_valid_q;
  assign mean_o      = s3_mean_q;
  assign temp_o      = s3_temp_q;
  assign status_o    = s3_status_q;

endmodule

@@ src/thermistor_window_average_lookup.sv @@
// Thermistor window average and table lookup.
// Input channel sample_i carries one ADC sample of the thermistor divider per
// transaction; output channel result_o returns, for each sample, the mean of
// the last WINDOW samples, the temperature in 5 degree steps and a range
// status (in table, below the first entry, past the last entry).
// Every accepted sample gives exactly one result, in order.
// Throughput: one transaction per cycle while the receiver does not stall; the
// front end updates the sample ring and running total for each accepted
// sample, which sets that rate. A result passes through the queue, the
// multiply stage, the mean correction stage and the output register.
// Reset clears the ring, the running total, the write slot, the queue and
// all pipeline stages at once; no clearing pass is needed.
// When the receiver stalls, the back-end stages fill, then the two-entry
// queue, and only then sample_i.ready drops; nothing is lost or repeated.
// depends on twal_pkg, twal_sample_if, twal_result_if, twal_front,
// twal_queue, twal_back, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module thermistor_window_average_lookup import twal_pkg::*; #(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  twal_sample_if.sink   sample_i,
  twal_result_if.source result_o
);

  localparam int unsigned TOTAL_BITS = SAMPLE_BITS + $clog2(WINDOW);

  logic                  push_valid, push_ready;
  logic [TOTAL_BITS-1:0] push_total;
  logic                  pop_valid, pop_ready;
  logic [TOTAL_BITS-1:0] pop_total;

  // ring update and running total
  twal_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .smp_valid_i   (sample_i.valid),
    .smp_ready_o   (sample_i.ready),
    .smp_i         (sample_i.sample),
    .total_valid_o (push_valid),
    .total_ready_i (push_ready),
    .total_o       (push_total)
  );

  // decoupling queue
  twal_queue #(
    .WIDTH (TOTAL_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_total),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_total)
  );

  // mean and temperature lookup
  twal_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .total_valid_i (pop_valid),
    .total_ready_o (pop_ready),
    .total_i       (pop_total),
    .res_valid_o   (result_o.valid),
    .res_ready_i   (result_o.ready),
    .mean_o        (result_o.mean_value),
    .temp_o        (result_o.temperature),
    .status_o      (result_o.range_status)
  );

  // checks on the lookup result
  `TWAL_ASSERT_NR(a_no_result_in_reset, !rst_ni |-> !result_o.valid, "result valid during reset")
  `TWAL_ASSERT(a_low_range, result_o.valid && (result_o.range_status == RANGE_LOW) |-> (result_o.temperature == '0) && (32'(result_o.mean_value) < 32'(THRESH[0])), "low range with wrong temperature or mean")
  `TWAL_ASSERT(a_high_range, result_o.valid && (result_o.range_status == RANGE_HIGH) |-> (result_o.temperature == TEMP_MAX) && (32'(result_o.mean_value) >= 32'(THRESH[TABLE_LEN-1])), "high range with wrong temperature or mean")
  `TWAL_ASSERT(a_in_range, result_o.valid && (result_o.range_status == RANGE_IN) |-> (result_o.temperature < TEMP_MAX) && (32'(result_o.mean_value) >= 32'(THRESH[0])), "in-range result out of bounds")

endmodule
